/* hdl/balanced_tree_node_index_unit_assert.svh */
// Assertion macros for the balanced tree node index unit
`ifndef BALANCED_TREE_NODE_INDEX_UNIT_ASSERT_SVH
`define BALANCED_TREE_NODE_INDEX_UNIT_ASSERT_SVH

// Check that a condition implies another in the same cycle
`define BTNI_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the following cycle
`define BTNI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/btni_pkg.sv */
// Types, codes and tree index arithmetic shared by the node index unit
`timescale 1ns / 1ps
`default_nettype none

package btni_pkg;

  localparam int IndexBits = 32;
  localparam int LvlBits   = $clog2(IndexBits + 1);
  localparam int AddrBits  = 3;

  typedef enum logic [3:0] {
    CMD_LEVEL    = 4'd0,
    CMD_ROOT     = 4'd1,
    CMD_LEFT     = 4'd2,
    CMD_RIGHT    = 4'd3,
    CMD_PARENT   = 4'd4,
    CMD_SIBLING  = 4'd5,
    CMD_IN_PATH  = 4'd6,
    CMD_ANCESTOR = 4'd7,
    CMD_DIRPATH  = 4'd8,
    CMD_COPATH   = 4'd9
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK          = 2'd0,
    STS_ZERO_TREE   = 2'd1,
    STS_UNREACHABLE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ONE,
    ST_INPATH,
    ST_PCHECK,
    ST_WALK
  } state_e;

  // Results of one pass through the shared node unit
  typedef struct packed {
    logic [LvlBits-1:0]   level;
    logic [IndexBits-1:0] left;
    logic [IndexBits-1:0] right;
    logic [IndexBits-1:0] up;
    logic [IndexBits-1:0] sib;
    logic [IndexBits-1:0] lowmask;
  } node_ops_t;

  // Smear the highest set bit down to bit zero
  function automatic logic [IndexBits:0] smear(input logic [IndexBits:0] d);
    logic [IndexBits:0] s;
    s = d;
    for (int i = 1; i <= IndexBits; i = i * 2) begin
      s = s | (s >> i);
    end
    return s;
  endfunction

  // Node arithmetic around the lowest zero bit of the index
  function automatic node_ops_t node_unit(input logic [IndexBits-1:0] x);
    logic [IndexBits-1:0] t;
    logic [IndexBits-1:0] low;
    logic [IndexBits-1:0] msb;
    logic [LvlBits-1:0]   enc;
    node_ops_t            r;
    t   = ~x & (x + IndexBits'(1));
    msb = {1'b1, {(IndexBits-1){1'b0}}};
    enc = '0;
    for (int i = 0; i < IndexBits; i++) begin
      if (t[i]) begin
        enc = enc | LvlBits'(i);
      end
    end
    r.level   = (t == '0) ? LvlBits'(IndexBits) : enc;
    low       = (t == '0) ? msb : (t >> 1);
    r.left    = x ^ low;
    r.right   = x[0] ? (x ^ (low | t)) : x;
    r.up      = (x | t) & ~(t << 1);
    r.sib     = (t == '0) ? (x ^ msb) : (x ^ (t << 1));
    r.lowmask = x ^ (x + IndexBits'(1));
    return r;
  endfunction

  // Root index for a non-zero leaf count, all ones when it does not fit
  function automatic logic [IndexBits-1:0] tree_root(input logic [IndexBits-1:0] n);
    logic [IndexBits:0] w;
    logic [IndexBits:0] s;
    w = {n, 1'b0} - (IndexBits + 1)'(1);
    s = smear(w);
    return s[IndexBits:1];
  endfunction

  // Lowest common ancestor of two leaves
  function automatic logic [IndexBits-1:0] leaf_ancestor(input logic [IndexBits-1:0] a,
                                                         input logic [IndexBits-1:0] b);
    logic [IndexBits-1:0] ln;
    logic [IndexBits-1:0] rn;
    logic [IndexBits:0]   s;
    ln = {a[IndexBits-2:0], 1'b0};
    rn = {b[IndexBits-2:0], 1'b0};
    s  = smear({1'b0, ln ^ rn});
    return (ln & ~s[IndexBits-1:0]) | s[IndexBits:1];
  endfunction

endpackage

`default_nettype wire

/* hdl/balanced_tree_node_index_unit.sv */
// Top level of the balanced tree node index unit: sequencer, shared node unit, register port
//
//  Channel   Direction  Handshake                     Payload
//  command   in         start high while busy low     command_i, node_a_i, node_b_i
//  result    out        valid_o strobe, one cycle     value_o, last_o, empty_path_o, status_o
//  config    in         psel, penable, pwrite, pready paddr, pwdata (prdata on reads)
//
// Busy after an accepted command: ST_ONE alone for level, root, left, right, parent,
// sibling, ancestor, unused codes and a path on a zero-leaf tree; ST_ONE, ST_INPATH for
// in_path; ST_ONE, ST_PCHECK for the empty path and an unreachable root; ST_ONE, ST_PCHECK
// and one ST_WALK per node for a path of n nodes (n up to 32). One shared node unit serves
// each cycle, so a path emits one node per cycle. Results are registered. Reset clears the
// sequencer, the strobe and leaf_count; the receiver takes every result as it is shown.
`timescale 1ns / 1ps
`default_nettype none
`include "balanced_tree_node_index_unit_assert.svh"

module balanced_tree_node_index_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [3:0]                      command_i,
  input  wire logic [btni_pkg::IndexBits-1:0]  node_a_i,
  input  wire logic [btni_pkg::IndexBits-1:0]  node_b_i,
  output logic                                 valid_o,
  output logic [btni_pkg::IndexBits-1:0]       value_o,
  output logic                                 last_o,
  output logic                                 empty_path_o,
  output logic [1:0]                           status_o,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [btni_pkg::AddrBits-1:0]   paddr,
  input  wire logic [31:0]                     pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);
  import btni_pkg::*;

  state_e               state_q, state_d;
  logic [3:0]           cmd_q;
  logic [IndexBits-1:0] a_q, b_q;
  logic [IndexBits-1:0] x_q, x_d;
  logic [LvlBits-1:0]   lvl_q, lvl_d;
  logic [LvlBits-1:0]   cnt_q, cnt_d;
  logic [IndexBits-1:0] leaf_count_q;

  logic                 valid_q, valid_d;
  logic [IndexBits-1:0] value_q, value_d;
  logic                 last_q, last_d;
  logic                 empty_q, empty_d;
  status_e              status_q, status_d;

  logic                 accept;
  logic [IndexBits-1:0] unit_x;
  node_ops_t            unit;
  logic [IndexBits-1:0] root;
  logic                 zero_tree;
  logic                 cfg_wr;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  // Configuration register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : leaf_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leaf_count_q <= '0;
    end else if (cfg_wr) begin
      leaf_count_q <= pwdata;
    end
  end

  assign root      = tree_root(leaf_count_q);
  assign zero_tree = (leaf_count_q == '0);

  // Pick the operand of the shared node unit
  always_comb begin
    case (state_q)
      ST_INPATH: unit_x = b_q;
      ST_PCHECK: unit_x = root;
      ST_WALK:   unit_x = x_q;
      default:   unit_x = a_q;
    endcase
  end

  assign unit = node_unit(unit_x);

  // Sequencer: next state and result forming
  always_comb begin
    state_d  = state_q;
    x_d      = x_q;
    lvl_d    = lvl_q;
    cnt_d    = cnt_q;
    valid_d  = 1'b0;
    value_d  = '0;
    last_d   = 1'b1;
    empty_d  = 1'b0;
    status_d = STS_OK;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_ONE;
        end
      end
      ST_ONE: begin
        state_d = ST_IDLE;
        case (cmd_e'(cmd_q))
          CMD_LEVEL: begin
            valid_d = 1'b1;
            value_d = IndexBits'(unit.level);
          end
          CMD_ROOT: begin
            valid_d = 1'b1;
            if (zero_tree) begin
              status_d = STS_ZERO_TREE;
            end else begin
              value_d = root;
            end
          end
          CMD_LEFT: begin
            valid_d = 1'b1;
            value_d = unit.left;
          end
          CMD_RIGHT: begin
            valid_d = 1'b1;
            value_d = unit.right;
          end
          CMD_PARENT: begin
            valid_d = 1'b1;
            value_d = unit.up;
          end
          CMD_SIBLING: begin
            valid_d = 1'b1;
            value_d = unit.sib;
          end
          CMD_IN_PATH: begin
            lvl_d   = unit.level;
            state_d = ST_INPATH;
          end
          CMD_ANCESTOR: begin
            valid_d = 1'b1;
            value_d = leaf_ancestor(a_q, b_q);
          end
          CMD_DIRPATH, CMD_COPATH: begin
            if (zero_tree) begin
              valid_d  = 1'b1;
              status_d = STS_ZERO_TREE;
            end else begin
              lvl_d   = unit.level;
              state_d = ST_PCHECK;
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_INPATH: begin
        valid_d = 1'b1;
        value_d = IndexBits'((lvl_q <= unit.level) &&
                             (((a_q ^ b_q) & ~unit.lowmask) == '0));
        state_d = ST_IDLE;
      end
      ST_PCHECK: begin
        // unit.level is the root level here; the node must sit below it in its subtree
        if (a_q == root) begin
          valid_d = 1'b1;
          empty_d = 1'b1;
          state_d = ST_IDLE;
        end else if ((lvl_q >= unit.level) ||
                     ((a_q & ~{root[IndexBits-2:0], 1'b1}) != '0)) begin
          valid_d  = 1'b1;
          status_d = STS_UNREACHABLE;
          state_d  = ST_IDLE;
        end else begin
          x_d     = a_q;
          cnt_d   = unit.level - lvl_q;
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        valid_d = 1'b1;
        value_d = (cmd_e'(cmd_q) == CMD_DIRPATH) ? unit.up : unit.sib;
        last_d  = (cnt_q == LvlBits'(1));
        x_d     = unit.up;
        cnt_d   = cnt_q - LvlBits'(1);
        if (cnt_q == LvlBits'(1)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  // Hold the operands of the accepted transfer and advance the walk
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= command_i;
      a_q   <= node_a_i;
      b_q   <= node_b_i;
    end
    x_q      <= x_d;
    lvl_q    <= lvl_d;
    cnt_q    <= cnt_d;
    value_q  <= value_d;
    last_q   <= last_d;
    empty_q  <= empty_d;
    status_q <= status_d;
  end

  assign valid_o      = valid_q;
  assign value_o      = value_q;
  assign last_o       = last_q;
  assign empty_path_o = empty_q;
  assign status_o     = status_q;

  // Error and empty-path results stand alone
  `BTNI_ASSERT_SAME(a_single_special, valid_o && (status_o != STS_OK || empty_path_o), last_o, "special result not marked last")
  // An accepted transfer keeps the unit busy
  `BTNI_ASSERT_NEXT(a_busy_after_start, start && !busy, busy, "busy low after accepted transfer")
  // More path nodes pending means the walk is still running
  `BTNI_ASSERT_SAME(a_walk_running, valid_o && !last_o, busy, "non-final result while idle")

endmodule

`default_nettype wire
